// File: sv/bytecode_operand_stack_alu_top_macros.svh
// assertion macros for the operand stack block
`ifndef BYTECODE_OPERAND_STACK_ALU_TOP_MACROS_SVH
`define BYTECODE_OPERAND_STACK_ALU_TOP_MACROS_SVH
`ifndef SYNTH
`define BOS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BOS_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BOS_ASSERT(label, clk, rst_n, prop)
`define BOS_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: sv/bos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bos_pkg;
  localparam int ACTION_BITS = 5;
  localparam int IMM_BITS = 32;
  localparam int STATUS_BITS = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_PUSH = 5'd0, ACT_POP = 5'd1, ACT_PEEK = 5'd2, ACT_DUP = 5'd3,
    ACT_ADD = 5'd4, ACT_SUB = 5'd5, ACT_MUL = 5'd6, ACT_DIV = 5'd7,
    ACT_AND = 5'd8, ACT_OR = 5'd9, ACT_SHL = 5'd10, ACT_SHR = 5'd11,
    ACT_NEG = 5'd12, ACT_INC = 5'd13, ACT_DEC = 5'd14, ACT_IFEQ = 5'd15,
    ACT_IFNE = 5'd16, ACT_GOTO = 5'd17, ACT_RET = 5'd18
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK = 2'd0, ST_OVERFLOW = 2'd1, ST_UNDERFLOW = 2'd2, ST_DIV_ZERO = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;     // capture action and operand
    logic rd_top;      // read entry count-1
    logic rd_second;   // read entry count-2
    logic exec;        // compute and check
    logic div_start;   // launch the divider
    logic commit;      // write back, update count, present result
  } bos_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic needs_second;
    logic is_div;
    logic div_done;
  } bos_stat_t;
endpackage
`default_nettype wire

// File: sv/bos_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module bos_divider #(
  parameter int WORD_BITS = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire [WORD_BITS-1:0]  dividend,
  input  wire [WORD_BITS-1:0]  divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quotient
);
  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   shifted;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    shifted = {rem_r, quo_r[WORD_BITS-1]};
    trial = shifted - {1'b0, den_r};
    if (start) begin
      neg_nxt = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      quo_nxt = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
      den_nxt = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
      rem_nxt = '0;
      cnt_nxt = CNT_BITS'(WORD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[WORD_BITS]) begin
        rem_nxt = trial[WORD_BITS-1:0];
        quo_nxt = {quo_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WORD_BITS-1:0];
        quo_nxt = {quo_r[WORD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;
endmodule
`default_nettype wire

// File: sv/bos_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bytecode_operand_stack_alu_top_macros.svh"
module bos_datapath #(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_BITS = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire bos_pkg::bos_cmd_t      cmd,
  output bos_pkg::bos_stat_t          stat,
  input  wire [bos_pkg::ACTION_BITS-1:0] in_action,
  input  wire signed [bos_pkg::IMM_BITS-1:0] in_operand,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_top_value,
  output logic                        out_branch_taken,
  output logic signed [31:0]          out_jump_offset,
  output logic [6:0]                  out_stack_depth
);
  localparam int CB = $clog2(STACK_DEPTH + 1);
  localparam int AB = $clog2(STACK_DEPTH);

  logic [WORD_BITS-1:0] mem [STACK_DEPTH];
  logic [WORD_BITS-1:0] rd_data_r, top_r, sec_r;
  logic [CB-1:0]        cnt_r, cnt_nxt;
  bos_pkg::action_t     act_r;
  logic [bos_pkg::ACTION_BITS-1:0] act_raw_r;
  logic [31:0]          opnd_r;
  logic                 rd_top_q_r, rd_sec_q_r;
  logic [AB-1:0]        rd_addr;
  logic [WORD_BITS-1:0] res_r, res_nxt, prod_r, imm_w, div_q;
  bos_pkg::status_t     st_r, st_nxt;
  logic                 taken_r, taken_nxt, wr_en_r, wr_en_nxt;
  logic [AB-1:0]        wr_addr_r, wr_addr_nxt;
  logic [CB-1:0]        cnt_new_r, cnt_new_nxt;
  logic [4:0]           sh;
  logic                 known, need1, need2, underflow;
  logic                 div_done;

  assign known = act_raw_r <= bos_pkg::ACT_RET;
  assign need2 = known && act_raw_r >= bos_pkg::ACT_ADD && act_raw_r <= bos_pkg::ACT_SHR;
  assign need1 = known && act_raw_r != bos_pkg::ACT_PUSH && act_raw_r != bos_pkg::ACT_GOTO;
  assign underflow = (need2 && cnt_r < CB'(2)) || (need1 && cnt_r == '0);
  assign stat.needs_second = need2 && !underflow;
  assign stat.is_div = act_raw_r == bos_pkg::ACT_DIV && !underflow && top_r != '0;
  assign stat.div_done = div_done;
  assign imm_w = WORD_BITS'($signed(opnd_r));
  assign sh = top_r[4:0];

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_raw_r <= in_action;
      opnd_r <= in_operand;
    end
  end
  assign act_r = bos_pkg::action_t'(act_raw_r);

  // stack memory, registered read
  always_comb begin
    rd_addr = cmd.rd_second ? AB'(cnt_r - CB'(2)) : AB'(cnt_r - CB'(1));
  end
  always_ff @(posedge clk) begin
    if (cmd.rd_top || cmd.rd_second) rd_data_r <= mem[rd_addr];
    if (wr_en_r && cmd.commit) mem[wr_addr_r] <= res_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_top_q_r <= 1'b0;
      rd_sec_q_r <= 1'b0;
    end else begin
      rd_top_q_r <= cmd.rd_top;
      rd_sec_q_r <= cmd.rd_second;
    end
  end
  always_ff @(posedge clk) begin
    if (rd_top_q_r) top_r <= (cnt_r == '0) ? '0 : rd_data_r;
    if (rd_sec_q_r) sec_r <= rd_data_r;
    prod_r <= sec_r * top_r;
  end

  bos_divider #(.WORD_BITS(WORD_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(sec_r), .divisor(top_r), .done(div_done), .quotient(div_q)
  );

  // execute: status, value, write-back plan
  always_comb begin
    st_nxt = bos_pkg::ST_OK;
    res_nxt = '0;
    taken_nxt = 1'b0;
    wr_en_nxt = 1'b0;
    wr_addr_nxt = AB'(cnt_r - CB'(1));
    cnt_new_nxt = cnt_r;
    if (underflow) begin
      st_nxt = bos_pkg::ST_UNDERFLOW;
    end else if ((act_raw_r == bos_pkg::ACT_PUSH || act_raw_r == bos_pkg::ACT_DUP)
                 && cnt_r >= CB'(STACK_DEPTH)) begin
      st_nxt = bos_pkg::ST_OVERFLOW;
    end else if (act_raw_r == bos_pkg::ACT_DIV && top_r == '0) begin
      st_nxt = bos_pkg::ST_DIV_ZERO;
    end else if (!known) begin
      res_nxt = top_r;
    end else begin
      unique case (act_r)
        bos_pkg::ACT_PUSH, bos_pkg::ACT_DUP: begin
          res_nxt = (act_r == bos_pkg::ACT_PUSH) ? imm_w : top_r;
          wr_en_nxt = 1'b1;
          wr_addr_nxt = AB'(cnt_r);
          cnt_new_nxt = cnt_r + 1'b1;
        end
        bos_pkg::ACT_POP, bos_pkg::ACT_RET: begin
          res_nxt = top_r;
          cnt_new_nxt = cnt_r - 1'b1;
        end
        bos_pkg::ACT_PEEK, bos_pkg::ACT_GOTO: begin
          res_nxt = top_r;
          taken_nxt = act_r == bos_pkg::ACT_GOTO;
        end
        bos_pkg::ACT_IFEQ, bos_pkg::ACT_IFNE: begin
          res_nxt = top_r;
          cnt_new_nxt = cnt_r - 1'b1;
          taken_nxt = (act_r == bos_pkg::ACT_IFEQ) ? (top_r == '0) : (top_r != '0);
        end
        bos_pkg::ACT_NEG, bos_pkg::ACT_INC, bos_pkg::ACT_DEC: begin
          wr_en_nxt = 1'b1;
          res_nxt = (act_r == bos_pkg::ACT_NEG) ? ('0 - top_r) :
                    (act_r == bos_pkg::ACT_INC) ? (top_r + 1'b1) : (top_r - 1'b1);
        end
        default: begin
          wr_en_nxt = 1'b1;
          wr_addr_nxt = AB'(cnt_r - CB'(2));
          cnt_new_nxt = cnt_r - 1'b1;
          case (act_r)
            bos_pkg::ACT_ADD: res_nxt = sec_r + top_r;
            bos_pkg::ACT_SUB: res_nxt = sec_r - top_r;
            bos_pkg::ACT_MUL: res_nxt = prod_r;
            bos_pkg::ACT_DIV: res_nxt = div_q;
            bos_pkg::ACT_AND: res_nxt = sec_r & top_r;
            bos_pkg::ACT_OR:  res_nxt = sec_r | top_r;
            bos_pkg::ACT_SHL: res_nxt = (32'(sh) >= 32'(WORD_BITS)) ? '0 : (sec_r << sh);
            default: res_nxt = (32'(sh) >= 32'(WORD_BITS)) ?
                               {WORD_BITS{sec_r[WORD_BITS-1]}} :
                               WORD_BITS'($signed(sec_r) >>> sh);
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_r <= st_nxt;
      res_r <= res_nxt;
      taken_r <= taken_nxt;
      wr_en_r <= wr_en_nxt;
      wr_addr_r <= wr_addr_nxt;
      cnt_new_r <= cnt_new_nxt;
    end
  end

  // depth register
  assign cnt_nxt = cmd.commit ? cnt_new_r : cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  // result ports, held until the next commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= st_r;
      out_top_value <= 32'(res_r);
      out_branch_taken <= taken_r;
      out_jump_offset <= taken_r ? opnd_r : '0;
      out_stack_depth <= 7'(cnt_new_r);
    end
  end

  `BOS_ASSERT(a_depth_range, clk, rst_n, cnt_r <= CB'(STACK_DEPTH))
  `BOS_ASSERT(a_err_no_write, clk, rst_n, (cmd.exec && st_nxt != bos_pkg::ST_OK) |=> !wr_en_r)
  `BOS_ASSERT(a_err_keeps_depth, clk, rst_n, (cmd.commit && st_r != bos_pkg::ST_OK) |=> $stable(cnt_r))
endmodule
`default_nettype wire

// File: sv/bos_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bytecode_operand_stack_alu_top_macros.svh"
module bos_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  output logic                out_valid,
  output bos_pkg::bos_cmd_t   cmd,
  input  wire bos_pkg::bos_stat_t stat
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001, S_RDTOP = 8'b0000_0010, S_WTOP = 8'b0000_0100,
    S_WSEC = 8'b0000_1000, S_MUL = 8'b0001_0000, S_DIV = 8'b0010_0000,
    S_EXEC = 8'b0100_0000, S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.load_in = 1'b1;
        state_nxt = S_RDTOP;
      end
      S_RDTOP: begin
        cmd.rd_top = 1'b1;
        state_nxt = S_WTOP;
      end
      S_WTOP: begin
        if (stat.needs_second) begin
          cmd.rd_second = 1'b1;
          state_nxt = S_WSEC;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      // second operand lands at the end of this cycle
      S_WSEC: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (stat.is_div) cmd.div_start = 1'b1;
        state_nxt = stat.is_div ? S_DIV : S_EXEC;
      end
      S_DIV: if (stat.div_done) state_nxt = S_EXEC;
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.commit;
    end
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = valid_r;

  `BOS_ASSERT(a_onehot, clk, rst_n, $onehot(state_r))
  `BOS_ASSERT(a_strobe_one, clk, rst_n, out_valid |=> !out_valid)
  `BOS_ASSERT(a_commit_after_exec, clk, rst_n, cmd.commit |-> $past(cmd.exec))
endmodule
`default_nettype wire

// File: sv/bytecode_operand_stack_alu_top.sv
// channel  | ports                                     | handshake
// input    | in_action, in_operand                     | start high, busy low
// result   | out_status .. out_stack_depth             | out_valid, one cycle
// an item is read, executed and committed in turn, with a second read
// for two operands and a divider wait for div; registered stack read,
// one quotient bit per cycle; busy drops in the result strobe cycle
// synchronous active-low reset empties the stack; entries are not cleared
// the receiver cannot stall: out_valid is high for one cycle per item
`timescale 1ns / 1ps
`default_nettype none
module bytecode_operand_stack_alu_top #(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_BITS = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire [4:0]         in_action,
  input  wire signed [31:0] in_operand,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic signed [31:0] out_top_value,
  output logic              out_branch_taken,
  output logic signed [31:0] out_jump_offset,
  output logic [6:0]        out_stack_depth
);
  bos_pkg::bos_cmd_t  cmd;
  bos_pkg::bos_stat_t stat;

  bos_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .cmd(cmd), .stat(stat)
  );

  bos_datapath #(.STACK_DEPTH(STACK_DEPTH), .WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_action(in_action), .in_operand(in_operand),
    .out_status(out_status), .out_top_value(out_top_value),
    .out_branch_taken(out_branch_taken), .out_jump_offset(out_jump_offset),
    .out_stack_depth(out_stack_depth)
  );
endmodule
`default_nettype wire
